// ===== hdl/nnd_pkg.sv =====
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared types and constants of the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nnd_pkg;

  // Width of one configuration register and of the register index.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // Width of the pixel field on both channels.
  localparam int PIX_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

  // One picked pixel on its way to the output stage.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } nnd_result_t;

endpackage

// ===== hdl/nnd_cfg.sv =====
// ----------------------------------------------------------------------------
// nnd_cfg
// Size registers and their clamping to the ranges the scaler supports.
// ----------------------------------------------------------------------------
module nnd_cfg #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnd_pkg::CFG_W-1:0]    cfg_data,
  output logic [COORD_BITS:0]          src_w,
  output logic [COORD_BITS:0]          src_h,
  output logic [COORD_BITS:0]          dst_w,
  output logic [COORD_BITS:0]          dst_h
);

  localparam int SZ_W  = COORD_BITS + 1;
  localparam int CMP_W = (nnd_pkg::CFG_W > SZ_W) ? nnd_pkg::CFG_W : SZ_W;
  localparam logic [CMP_W-1:0] LIM = CMP_W'(2 ** COORD_BITS);

  logic [nnd_pkg::CFG_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [CMP_W-1:0]          sw_c, sh_c, dw_c, dh_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnd_pkg::RST_WIDTH;
      src_h_r <= nnd_pkg::RST_HEIGHT;
      dst_w_r <= nnd_pkg::RST_WIDTH;
      dst_h_r <= nnd_pkg::RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nnd_pkg::REG_SRC_WIDTH:  src_w_r <= cfg_data;
        nnd_pkg::REG_SRC_HEIGHT: src_h_r <= cfg_data;
        nnd_pkg::REG_DST_WIDTH:  dst_w_r <= cfg_data;
        nnd_pkg::REG_DST_HEIGHT: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero counts as one; the source size is capped at the coordinate
  // range and the destination size at the source size.
  always_comb begin
    sw_c = CMP_W'(src_w_r);
    if (sw_c == '0) sw_c = CMP_W'(1);
    else if (sw_c > LIM) sw_c = LIM;

    sh_c = CMP_W'(src_h_r);
    if (sh_c == '0) sh_c = CMP_W'(1);
    else if (sh_c > LIM) sh_c = LIM;

    dw_c = CMP_W'(dst_w_r);
    if (dw_c == '0) dw_c = CMP_W'(1);
    else if (dw_c > sw_c) dw_c = sw_c;

    dh_c = CMP_W'(dst_h_r);
    if (dh_c == '0) dh_c = CMP_W'(1);
    else if (dh_c > sh_c) dh_c = sh_c;
  end

  assign src_w = sw_c[SZ_W-1:0];
  assign src_h = sh_c[SZ_W-1:0];
  assign dst_w = dw_c[SZ_W-1:0];
  assign dst_h = dh_c[SZ_W-1:0];

endmodule

// ===== hdl/nnd_core.sv =====
// ----------------------------------------------------------------------------
// nnd_core
// Raster position tracking and the pick decision for each source pixel.
// ----------------------------------------------------------------------------
module nnd_core #(
  parameter int COORD_BITS  = 12,
  parameter int PIXEL_BYTES = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_acc,
  input  logic [nnd_pkg::PIX_W-1:0] pixel_in,
  input  logic                      frame_start,
  input  logic [COORD_BITS:0]       src_w,
  input  logic [COORD_BITS:0]       src_h,
  input  logic [COORD_BITS:0]       dst_w,
  input  logic [COORD_BITS:0]       dst_h,
  output logic                      push,
  output nnd_pkg::nnd_result_t      push_data
);

  localparam int CW    = COORD_BITS;
  localparam int SZ_W  = CW + 1;
  localparam int ACC_W = 2 * CW + 1;
  localparam int LIM   = 2 ** CW;
  localparam int RST_DW = (640 > LIM) ? LIM : 640;
  localparam int RST_DH = (480 > LIM) ? LIM : 480;
  localparam int PB_BITS = PIXEL_BYTES * 8;
  localparam logic [nnd_pkg::PIX_W-1:0] PIX_MASK =
    nnd_pkg::PIX_W'((33'd1 << PB_BITS) - 33'd1);

  logic [CW-1:0]    src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [SZ_W-1:0]  dst_col_r, dst_col_nxt, dst_row_r, dst_row_nxt;
  logic [ACC_W-1:0] ct_r, ct_nxt, cb_r, cb_nxt, rt_r, rt_nxt, rb_r, rb_nxt;
  logic             rsel_r, rsel_nxt;

  // Position after an optional frame restart.
  logic [CW-1:0]    e_src_col, e_src_row;
  logic [SZ_W-1:0]  e_dst_col, e_dst_row;
  logic [ACC_W-1:0] e_ct, e_cb, e_rt, e_rb;
  logic             e_rsel;

  logic [ACC_W-1:0] sw_a, sh_a, dw_a, dh_a;
  logic [SZ_W-1:0]  col_inc, row_inc;
  logic             pick, row_last, frame_last, row_step;
  logic [SZ_W-1:0]  dr_step;
  logic [ACC_W-1:0] rt_step, rb_step;

  assign sw_a = ACC_W'(src_w);
  assign sh_a = ACC_W'(src_h);
  assign dw_a = ACC_W'(dst_w);
  assign dh_a = ACC_W'(dst_h);

  always_comb begin
    if (frame_start) begin
      e_src_col = '0;
      e_src_row = '0;
      e_dst_col = '0;
      e_dst_row = '0;
      e_ct      = '0;
      e_cb      = dw_a;
      e_rt      = '0;
      e_rb      = dh_a;
      e_rsel    = 1'b1;
    end else begin
      e_src_col = src_col_r;
      e_src_row = src_row_r;
      e_dst_col = dst_col_r;
      e_dst_row = dst_row_r;
      e_ct      = ct_r;
      e_cb      = cb_r;
      e_rt      = rt_r;
      e_rb      = rb_r;
      e_rsel    = rsel_r;
    end
  end

  // Column x is picked while dst_col * sw < (x + 1) * dw.
  assign pick       = e_rsel && (e_dst_col < dst_w) && (e_ct < e_cb);
  assign col_inc    = SZ_W'(e_src_col) + SZ_W'(1);
  assign row_inc    = SZ_W'(e_src_row) + SZ_W'(1);
  assign row_last   = (col_inc >= src_w);
  assign frame_last = (row_inc >= src_h);
  assign row_step   = e_rsel && (e_dst_row < dst_h);
  assign dr_step    = e_dst_row + SZ_W'(row_step);
  assign rt_step    = row_step ? (e_rt + sh_a) : e_rt;
  assign rb_step    = e_rb + dh_a;

  assign push                = in_acc && pick;
  assign push_data.pixel     = pixel_in & PIX_MASK;
  assign push_data.row_end   = (e_dst_col == (dst_w - SZ_W'(1)));
  assign push_data.frame_end = push_data.row_end && (e_dst_row == (dst_h - SZ_W'(1)));

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    dst_col_nxt = dst_col_r;
    dst_row_nxt = dst_row_r;
    ct_nxt      = ct_r;
    cb_nxt      = cb_r;
    rt_nxt      = rt_r;
    rb_nxt      = rb_r;
    rsel_nxt    = rsel_r;
    if (in_acc) begin
      src_row_nxt = e_src_row;
      dst_row_nxt = e_dst_row;
      rt_nxt      = e_rt;
      rb_nxt      = e_rb;
      rsel_nxt    = e_rsel;
      if (row_last) begin
        src_col_nxt = '0;
        dst_col_nxt = '0;
        ct_nxt      = '0;
        cb_nxt      = dw_a;
        if (frame_last) begin
          src_row_nxt = '0;
          dst_row_nxt = '0;
          rt_nxt      = '0;
          rb_nxt      = dh_a;
          rsel_nxt    = 1'b1;
        end else begin
          src_row_nxt = row_inc[CW-1:0];
          dst_row_nxt = dr_step;
          rt_nxt      = rt_step;
          rb_nxt      = rb_step;
          rsel_nxt    = (dr_step < dst_h) && (rt_step < rb_step);
        end
      end else begin
        src_col_nxt = col_inc[CW-1:0];
        dst_col_nxt = e_dst_col + SZ_W'(pick);
        ct_nxt      = pick ? (e_ct + sw_a) : e_ct;
        cb_nxt      = e_cb + dw_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      dst_col_r <= '0;
      dst_row_r <= '0;
      ct_r      <= '0;
      cb_r      <= ACC_W'(RST_DW);
      rt_r      <= '0;
      rb_r      <= ACC_W'(RST_DH);
      rsel_r    <= 1'b1;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      dst_col_r <= dst_col_nxt;
      dst_row_r <= dst_row_nxt;
      ct_r      <= ct_nxt;
      cb_r      <= cb_nxt;
      rt_r      <= rt_nxt;
      rb_r      <= rb_nxt;
      rsel_r    <= rsel_nxt;
    end
  end

endmodule

// ===== hdl/nnd_outbuf.sv =====
// ----------------------------------------------------------------------------
// nnd_outbuf
// Output register with a skid entry, so input ready never waits on the sink.
// ----------------------------------------------------------------------------
module nnd_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nnd_pkg::nnd_result_t push_data,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nnd_pkg::nnd_result_t out_data
);

  logic                 main_v_r, skid_v_r;
  nnd_pkg::nnd_result_t main_d_r, skid_d_r;
  logic                 pop;

  assign pop       = main_v_r && out_ready;
  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      if (main_v_r) begin
        skid_d_r <= push_data;
      end else begin
        main_d_r <= push_data;
      end
    end
  end

endmodule

// ===== hdl/nearest_neighbor_downscaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Nearest-neighbor downscale of a raster-order pixel stream.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock and passes on the pixels that a
// nearest-neighbor downscale to the configured destination size picks. Each
// beat is decided in the cycle it is accepted, from the position counters and
// the cross-multiplied accumulators, and a picked pixel is registered in the
// output register, or in its skid entry while that register is held. Sustained
// rate is one pixel per cycle; the input stalls only when both the output
// register and its skid entry are full. Sizes take effect at once, and a
// destination size above the source size counts as the source size.
module nearest_neighbor_downscaler #(
  parameter int COORD_BITS  = 12,
  parameter int PIXEL_BYTES = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // [23:0] pixel_in
  input  logic                          in_tuser,   // [0] frame_start
  // Output stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [23:0] pixel_out
  output logic                          out_tlast,  // row_end
  output logic                          out_tuser,  // [0] frame_end
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnd_pkg::CFG_W-1:0]     cfg_data
);

  logic [COORD_BITS:0]  src_w, src_h, dst_w, dst_h;
  logic                 in_acc, push;
  nnd_pkg::nnd_result_t push_data, out_data;

  assign in_acc = in_tvalid && in_tready;

  nnd_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_w     (src_w),
    .src_h     (src_h),
    .dst_w     (dst_w),
    .dst_h     (dst_h)
  );

  nnd_core #(
    .COORD_BITS  (COORD_BITS),
    .PIXEL_BYTES (PIXEL_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .pixel_in    (in_tdata),
    .frame_start (in_tuser),
    .src_w       (src_w),
    .src_h       (src_h),
    .dst_w       (dst_w),
    .dst_h       (dst_h),
    .push        (push),
    .push_data   (push_data)
  );

  nnd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = out_data.pixel;
  assign out_tlast = out_data.row_end;
  assign out_tuser = out_data.frame_end;

  // The last pixel of a frame is always the last pixel of its row.
  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("frame_end without row_end");

  // The skid entry only fills behind a held output beat.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output register");

  // Reset empties the output stage.
  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
